// ===== hdl/digraph_square_cipher_encrypt_macros.svh =====
// assertion macros used by the checker file
`ifndef DIGRAPH_SQUARE_CIPHER_ENCRYPT_MACROS_SVH
`define DIGRAPH_SQUARE_CIPHER_ENCRYPT_MACROS_SVH

// same-cycle implication on clk, held off while arst_n is low
`define DSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, held off while arst_n is low
`define DSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dsq_pkg.sv =====
// shared types and constants of the digraph square encryptor
`timescale 1ns / 1ps

package dsq_pkg;

	localparam int SQUARE_SIDE = 5;
	localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
	localparam int LETTERS     = 26;
	localparam int CODE_W      = $clog2(LETTERS);
	localparam int CELL_W      = $clog2(CELL_COUNT);
	localparam int POS_W       = $clog2(SQUARE_SIDE);
	localparam int OP_W        = 3;
	localparam int BYTE_W      = 8;
	localparam int CHAR_W      = 7;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// input op codes
	localparam logic [OP_W-1:0] OP_KEY_START  = 3'd0;
	localparam logic [OP_W-1:0] OP_KEY_LETTER = 3'd1;
	localparam logic [OP_W-1:0] OP_KEY_FINISH = 3'd2;
	localparam logic [OP_W-1:0] OP_MSG_LETTER = 3'd3;
	localparam logic [OP_W-1:0] OP_MSG_END    = 3'd4;

	// letter codes, 0 is A
	localparam logic [CODE_W-1:0] CODE_I = 5'd8;
	localparam logic [CODE_W-1:0] CODE_J = 5'd9;
	localparam logic [CODE_W-1:0] CODE_X = 5'd23;

	localparam logic [BYTE_W-1:0] ASCII_UA = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UZ = 8'h5A;
	localparam logic [BYTE_W-1:0] ASCII_LA = 8'h61;
	localparam logic [BYTE_W-1:0] ASCII_LZ = 8'h7A;
	localparam logic [CHAR_W-1:0] CHAR_A   = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_J   = 7'h4A;
	localparam logic [CHAR_W-1:0] CHAR_Z   = 7'h5A;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] char_byte;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cipher_char;
		logic              pair_end;
	} letter_t;

	typedef enum logic [2:0] {
		CMD_KEY_START,
		CMD_KEY_LETTER,
		CMD_KEY_FINISH,
		CMD_MSG_LETTER,
		CMD_MSG_END
	} cmd_t;

	// classified request as it sits in the queue
	typedef struct packed {
		cmd_t              cmd;
		logic [CODE_W-1:0] code;
	} cmd_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FINISH,
		ST_LOOKUP,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

endpackage

// ===== hdl/dsq_front.sv =====
// front end: folds the character byte and classifies each request
`timescale 1ns / 1ps

module dsq_front (
	input  logic                item_valid,
	output logic                item_stall,
	input  dsq_pkg::item_t      item,
	input  logic                q_full,
	output logic                push,
	output dsq_pkg::cmd_entry_t push_entry
);

	logic                      is_letter;
	logic [dsq_pkg::CODE_W-1:0] code;
	logic                      keep;

	// case fold, J to I
	always_comb begin
		is_letter = 1'b0;
		code      = '0;
		if (item.char_byte >= dsq_pkg::ASCII_UA && item.char_byte <= dsq_pkg::ASCII_UZ) begin
			is_letter = 1'b1;
			code      = dsq_pkg::CODE_W'(item.char_byte - dsq_pkg::ASCII_UA);
		end else if (item.char_byte >= dsq_pkg::ASCII_LA &&
				item.char_byte <= dsq_pkg::ASCII_LZ) begin
			is_letter = 1'b1;
			code      = dsq_pkg::CODE_W'(item.char_byte - dsq_pkg::ASCII_LA);
		end
		if (code == dsq_pkg::CODE_J) begin
			code = dsq_pkg::CODE_I;
		end
	end

	// requests with no effect are taken and dropped here
	always_comb begin
		keep           = 1'b0;
		push_entry.cmd = dsq_pkg::CMD_KEY_START;
		push_entry.code = code;
		unique case (item.op)
			dsq_pkg::OP_KEY_START: begin
				keep           = 1'b1;
				push_entry.cmd = dsq_pkg::CMD_KEY_START;
			end
			dsq_pkg::OP_KEY_LETTER: begin
				keep           = is_letter;
				push_entry.cmd = dsq_pkg::CMD_KEY_LETTER;
			end
			dsq_pkg::OP_KEY_FINISH: begin
				keep           = 1'b1;
				push_entry.cmd = dsq_pkg::CMD_KEY_FINISH;
			end
			dsq_pkg::OP_MSG_LETTER: begin
				keep           = is_letter;
				push_entry.cmd = dsq_pkg::CMD_MSG_LETTER;
			end
			dsq_pkg::OP_MSG_END: begin
				keep           = 1'b1;
				push_entry.cmd = dsq_pkg::CMD_MSG_END;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full && keep;

endmodule

// ===== hdl/dsq_queue.sv =====
// short queue of classified requests between front and back
`timescale 1ns / 1ps

module dsq_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dsq_pkg::cmd_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output dsq_pkg::cmd_entry_t head,
	output logic                head_valid
);

	dsq_pkg::cmd_entry_t        slot_q [dsq_pkg::QUEUE_DEPTH];
	logic [dsq_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dsq_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dsq_pkg::QCNT_W-1:0] count_q;
	logic                       do_push;
	logic                       do_pop;

	function automatic logic [dsq_pkg::QPTR_W-1:0] ptr_next(logic [dsq_pkg::QPTR_W-1:0] p);
		return (p == dsq_pkg::QPTR_W'(dsq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full       = (count_q == dsq_pkg::QCNT_W'(dsq_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/dsq_back.sv =====
// back end: key square builder, pairing and digraph encoder
`timescale 1ns / 1ps

module dsq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dsq_pkg::cmd_entry_t head,
	input  logic                head_valid,
	output logic                pop,
	output logic                letter_valid,
	input  logic                letter_stall,
	output dsq_pkg::letter_t    letter
);

	localparam int CODE_W = dsq_pkg::CODE_W;
	localparam int CELL_W = dsq_pkg::CELL_W;
	localparam int POS_W  = dsq_pkg::POS_W;
	localparam int SIDE   = dsq_pkg::SQUARE_SIDE;

	dsq_pkg::state_t state_q;
	dsq_pkg::state_t state_nxt;

	logic [dsq_pkg::LETTERS-1:0] used_q;
	logic [CELL_W-1:0]           fill_q;
	logic                        pend_valid_q;
	logic [CODE_W-1:0]           pend_q;
	logic [CODE_W-1:0]           sweep_q;

	// letter -> cell and cell -> letter stores
	logic [CELL_W-1:0] cell_idx_mem [dsq_pkg::LETTERS];
	logic [CODE_W-1:0] square_mem   [dsq_pkg::CELL_COUNT];
	logic [CELL_W-1:0] ia_q;
	logic [CELL_W-1:0] ib_q;
	logic [CODE_W-1:0] sa_q;
	logic [CODE_W-1:0] sb_q;

	logic              letter_valid_q;
	dsq_pkg::letter_t  letter_q;

	logic              key_ready;
	logic              encode_req;
	logic              place_req;
	logic              place_en;
	logic [CODE_W-1:0] place_code;
	logic [CODE_W-1:0] pair_b;
	logic              lci_re;
	logic              sq_re;
	logic              out_free;
	logic              out_load;
	logic [CELL_W-1:0] o1;
	logic [CELL_W-1:0] o2;
	logic [POS_W-1:0]  r1, c1, r2, c2;

	function automatic logic [POS_W-1:0] row_of(logic [CELL_W-1:0] idx);
		logic [POS_W-1:0] r;
		r = '0;
		for (int i = 1; i < SIDE; i++) begin
			if (idx >= CELL_W'(i * SIDE)) begin
				r = POS_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] col_of(logic [CELL_W-1:0] idx, logic [POS_W-1:0] r);
		return POS_W'(idx - CELL_W'(r) * CELL_W'(SIDE));
	endfunction

	function automatic logic [CELL_W-1:0] cell_at(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
		return CELL_W'(r) * CELL_W'(SIDE) + CELL_W'(c);
	endfunction

	function automatic logic [POS_W-1:0] wrap_inc(logic [POS_W-1:0] x);
		return (x == POS_W'(SIDE - 1)) ? '0 : x + 1'b1;
	endfunction

	assign key_ready = (fill_q == CELL_W'(dsq_pkg::CELL_COUNT));
	assign out_free  = !letter_valid_q || !letter_stall;

	// a message request that completes a pair
	assign encode_req = key_ready && pend_valid_q &&
		(head.cmd == dsq_pkg::CMD_MSG_LETTER || head.cmd == dsq_pkg::CMD_MSG_END);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dsq_pkg::ST_IDLE: begin
				if (head_valid) begin
					if (head.cmd == dsq_pkg::CMD_KEY_FINISH) begin
						state_nxt = dsq_pkg::ST_FINISH;
					end else if (encode_req) begin
						state_nxt = dsq_pkg::ST_LOOKUP;
					end
				end
			end
			dsq_pkg::ST_FINISH: begin
				if (sweep_q == CODE_W'(dsq_pkg::LETTERS - 1)) begin
					state_nxt = dsq_pkg::ST_IDLE;
				end
			end
			dsq_pkg::ST_LOOKUP: begin
				state_nxt = dsq_pkg::ST_EMIT0;
			end
			dsq_pkg::ST_EMIT0: begin
				if (out_free) begin
					state_nxt = dsq_pkg::ST_EMIT1;
				end
			end
			dsq_pkg::ST_EMIT1: begin
				if (out_free) begin
					state_nxt = dsq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dsq_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop        = 1'b0;
		place_req  = 1'b0;
		place_code = head.code;
		lci_re     = 1'b0;
		sq_re      = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			dsq_pkg::ST_IDLE: begin
				pop        = head_valid;
				place_req  = head_valid && (head.cmd == dsq_pkg::CMD_KEY_LETTER);
				lci_re     = head_valid && encode_req;
			end
			dsq_pkg::ST_FINISH: begin
				place_code = sweep_q;
				place_req  = (sweep_q != dsq_pkg::CODE_J);
			end
			dsq_pkg::ST_LOOKUP: begin
				sq_re = 1'b1;
			end
			dsq_pkg::ST_EMIT0,
			dsq_pkg::ST_EMIT1: begin
				out_load = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign place_en = place_req && !key_ready && !used_q[place_code];

	// second letter: X on a doubled letter or at message end
	assign pair_b = (head.cmd == dsq_pkg::CMD_MSG_LETTER && head.code != pend_q) ?
		head.code : dsq_pkg::CODE_X;

	// row, column and the three digraph rules
	always_comb begin
		r1 = row_of(ia_q);
		r2 = row_of(ib_q);
		c1 = col_of(ia_q, r1);
		c2 = col_of(ib_q, r2);
		if (r1 == r2) begin
			o1 = cell_at(r1, wrap_inc(c1));
			o2 = cell_at(r2, wrap_inc(c2));
		end else if (c1 == c2) begin
			o1 = cell_at(wrap_inc(r1), c1);
			o2 = cell_at(wrap_inc(r2), c2);
		end else begin
			o1 = cell_at(r1, c2);
			o2 = cell_at(r2, c1);
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			cell_idx_mem[place_code] <= fill_q;
		end
		if (lci_re) begin
			ia_q <= cell_idx_mem[pend_q];
			ib_q <= cell_idx_mem[pair_b];
		end
	end

	always_ff @(posedge clk) begin
		if (place_en) begin
			square_mem[fill_q] <= place_code;
		end
		if (sq_re) begin
			sa_q <= square_mem[o1];
			sb_q <= square_mem[o2];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			letter_q.cipher_char <= (state_q == dsq_pkg::ST_EMIT0) ?
				dsq_pkg::CHAR_A + dsq_pkg::CHAR_W'(sa_q) :
				dsq_pkg::CHAR_A + dsq_pkg::CHAR_W'(sb_q);
			letter_q.pair_end    <= (state_q == dsq_pkg::ST_EMIT1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= dsq_pkg::ST_IDLE;
			used_q         <= '0;
			fill_q         <= '0;
			pend_valid_q   <= 1'b0;
			pend_q         <= '0;
			sweep_q        <= '0;
			letter_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (place_en) begin
				used_q[place_code] <= 1'b1;
				fill_q             <= fill_q + 1'b1;
			end
			if (state_q == dsq_pkg::ST_FINISH) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (pop) begin
				unique case (head.cmd)
					dsq_pkg::CMD_KEY_START: begin
						used_q       <= '0;
						fill_q       <= '0;
						pend_valid_q <= 1'b0;
						pend_q       <= '0;
					end
					dsq_pkg::CMD_KEY_FINISH: begin
						sweep_q      <= '0;
						pend_valid_q <= 1'b0;
						pend_q       <= '0;
					end
					dsq_pkg::CMD_MSG_LETTER: begin
						if (key_ready) begin
							if (!pend_valid_q) begin
								pend_valid_q <= 1'b1;
								pend_q       <= head.code;
							end else if (head.code != pend_q) begin
								pend_valid_q <= 1'b0;
							end
						end
					end
					dsq_pkg::CMD_MSG_END: begin
						if (key_ready) begin
							pend_valid_q <= 1'b0;
						end
					end
					default: begin
						pend_valid_q <= pend_valid_q;
					end
				endcase
			end
			if (out_load) begin
				letter_valid_q <= 1'b1;
			end else if (!letter_stall) begin
				letter_valid_q <= 1'b0;
			end
		end
	end

	assign letter_valid = letter_valid_q;
	assign letter       = letter_q;

endmodule

// ===== hdl/digraph_square_cipher_encrypt.sv =====
// top level of the digraph square encryptor
`timescale 1ns / 1ps

// Digraph square encryptor with its own 5x5 key-square builder. Requests
// (op, char_byte) enter on the item channel; cipher letters leave one per
// transfer on the letter channel, pair_end marking the second letter of each
// digraph. A front end takes one request per cycle, folds case and J to I,
// drops non-letters and unused op codes, and puts the classified request in a
// two-entry queue; the back end carries requests out one at a time. Key start
// and key letters are carried out as they are taken; key finish takes the
// request and then sweeps the alphabet, one letter a cycle. A message letter
// that only opens a pair is just stored; one that closes a pair, and
// message end with a letter waiting, go through these steps: read both
// letters' cell numbers, find the output cells and read the square, and load
// each cipher letter into the output register in turn. The back end takes no
// new request until both cipher letters are loaded. The output register lets
// the back end load the second letter while the first is taken; a stall on
// the letter channel holds the back end, and once the queue fills the item
// channel stalls. Message requests before the square holds all 25 letters are
// dropped without result.
module digraph_square_cipher_encrypt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dsq_pkg::item_t      item,
	output logic                letter_valid,
	input  logic                letter_stall,
	output dsq_pkg::letter_t    letter
);

	// front to queue
	logic                q_full;
	logic                push;
	dsq_pkg::cmd_entry_t push_entry;

	// queue to back
	logic                pop;
	logic                head_valid;
	dsq_pkg::cmd_entry_t head;

	// classify and fold each request
	dsq_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples request intake from the encoder
	dsq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// key square, pairing state and digraph encoding
	dsq_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.letter_valid (letter_valid),
		.letter_stall (letter_stall),
		.letter       (letter)
	);

endmodule

// ===== hdl/dsq_checker.sv =====
// port-level checks of the digraph square encryptor and their binding
`timescale 1ns / 1ps
`include "digraph_square_cipher_encrypt_macros.svh"

module dsq_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input dsq_pkg::item_t   item,
	input logic             letter_valid,
	input logic             letter_stall,
	input dsq_pkg::letter_t letter
);

	logic letter_take;
	logic letter_held;
	logic item_held;
	logic first_take;
	logic second_ready;
	logic letter_in_range;
	logic letter_is_j;

	assign letter_take     = letter_valid && !letter_stall;
	assign letter_held     = letter_valid && letter_stall;
	assign item_held       = item_valid && item_stall;
	assign first_take      = letter_take && !letter.pair_end;
	assign second_ready    = letter_valid && letter.pair_end;
	assign letter_in_range = (letter.cipher_char >= dsq_pkg::CHAR_A) &&
		(letter.cipher_char <= dsq_pkg::CHAR_Z);
	assign letter_is_j     = (letter.cipher_char == dsq_pkg::CHAR_J);

	// a held letter stays put
	`DSQ_ASSERT_NEXT(a_letter_hold, letter_held, letter_valid && $stable(letter), "letter moved")

	// a held request stays put
	`DSQ_ASSERT_NEXT(a_item_hold, item_held, item_valid && $stable(item), "request moved")

	// only uppercase letters
	`DSQ_ASSERT_NOW(a_letter_range, letter_valid, letter_in_range, "cipher letter out of range")

	// J never sits in the square
	`DSQ_ASSERT_NOW(a_no_j, letter_valid, !letter_is_j, "cipher letter J")

	// second letter of a digraph follows the first at once
	`DSQ_ASSERT_NEXT(a_pair_follows, first_take, second_ready, "second letter of digraph missing")

endmodule

bind digraph_square_cipher_encrypt dsq_checker u_dsq_checker (.*);
